// ----- hdl/tlca_pkg.sv -----
`default_nettype none

package tlca_pkg;

    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned BYTE_W     = 40;
    localparam int unsigned REQ_BYTE_W = 32;
    localparam int unsigned SLOT_FIELD_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam int unsigned QUERY_SLOTS_DEFAULT = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_OPEN           = 3'd0;
    localparam logic [2:0] ACT_RESERVE_RANGE  = 3'd1;
    localparam logic [2:0] ACT_RESERVE_WB     = 3'd2;
    localparam logic [2:0] ACT_RELEASE_RANGE  = 3'd3;
    localparam logic [2:0] ACT_RELEASE_RESV   = 3'd4;
    localparam logic [2:0] ACT_CANCEL         = 3'd5;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_CANCELLED     = 3'd1;
    localparam logic [2:0] ST_QUERY_RANGES  = 3'd2;
    localparam logic [2:0] ST_QUERY_BYTES   = 3'd3;
    localparam logic [2:0] ST_GLOBAL_RANGES = 3'd4;
    localparam logic [2:0] ST_GLOBAL_BYTES  = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW     = 3'd6;
    localparam logic [2:0] ST_ZERO_BYTES    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MAX_RANGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MAX_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_MAX_RANGES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_MAX_BYTES   = 2'd3;

    localparam logic [RANGE_W-1:0] GLOBAL_MAX_RANGES_RST = 16'd64;
    localparam logic [BYTE_W-1:0]  GLOBAL_MAX_BYTES_RST  = 40'd268435456;
    localparam logic [RANGE_W-1:0] QUERY_MAX_RANGES_RST  = 16'd16;
    localparam logic [BYTE_W-1:0]  QUERY_MAX_BYTES_RST   = 40'd67108864;

    typedef struct packed {
        logic [2:0]              action;
        logic [SLOT_FIELD_W-1:0] query_slot;
        logic [REQ_BYTE_W-1:0]   bytes;
        logic                    range_held;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       granted;
    } out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_OPEN,
        OP_CANCEL,
        OP_RESERVE,
        OP_ZERO,
        OP_RELEASE
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [REQ_BYTE_W-1:0]   bytes;
        logic                    take_range;
        logic                    rel_bytes;
        logic                    rel_range;
    } op_t;

endpackage

`default_nettype wire

// ----- hdl/tlca_front.sv -----
`default_nettype none

module tlca_front #(
    parameter int unsigned QUERY_SLOTS = tlca_pkg::QUERY_SLOTS_DEFAULT
) (
    input  tlca_pkg::in_t req,
    output tlca_pkg::op_t op
);
    import tlca_pkg::*;

    logic slot_ok;
    logic zero_bytes;

    assign slot_ok    = 32'(req.query_slot) < 32'(QUERY_SLOTS);
    assign zero_bytes = (req.bytes == '0);

    always_comb
    begin
        op            = '0;
        op.kind       = OP_NONE;
        op.slot       = req.query_slot;
        op.bytes      = req.bytes;
        if (slot_ok)
        begin
            case (req.action)
                ACT_OPEN:
                begin
                    op.kind = OP_OPEN;
                end
                ACT_CANCEL:
                begin
                    op.kind = OP_CANCEL;
                end
                ACT_RESERVE_RANGE, ACT_RESERVE_WB:
                begin
                    op.kind       = zero_bytes ? OP_ZERO : OP_RESERVE;
                    op.take_range = (req.action == ACT_RESERVE_RANGE);
                end
                ACT_RELEASE_RANGE:
                begin
                    op.kind      = OP_RELEASE;
                    op.rel_range = 1'b1;
                end
                ACT_RELEASE_RESV:
                begin
                    op.kind      = OP_RELEASE;
                    op.rel_bytes = !zero_bytes;
                    op.rel_range = req.range_held;
                end
                default:
                begin
                    op.kind = OP_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tlca_queue.sv -----
`default_nettype none

module tlca_queue (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  tlca_pkg::op_t push_op,
    output logic          full,
    input  wire           pop,
    output logic          not_empty,
    output tlca_pkg::op_t head
);
    import tlca_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tlca_back.sv -----
`default_nettype none

module tlca_back #(
    parameter int unsigned QUERY_SLOTS = tlca_pkg::QUERY_SLOTS_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write,
    input  wire  [tlca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tlca_pkg::BYTE_W-1:0]       cfg_data,
    input  wire                               op_valid,
    input  tlca_pkg::op_t                     op,
    output logic                              op_pop,
    output logic                              out_valid,
    input  wire                               out_stall,
    output tlca_pkg::out_t                    out_data
);
    import tlca_pkg::*;

    // slot field is four bits wide, so no more than sixteen slots are reachable
    localparam int unsigned MAX_SLOTS  = 1 << SLOT_FIELD_W;
    localparam int unsigned SLOT_DEPTH = (QUERY_SLOTS < MAX_SLOTS) ? QUERY_SLOTS : MAX_SLOTS;
    localparam int unsigned SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    logic [RANGE_W-1:0] gmax_ranges_reg;
    logic [BYTE_W-1:0]  gmax_bytes_reg;
    logic [RANGE_W-1:0] qmax_ranges_reg;
    logic [BYTE_W-1:0]  qmax_bytes_reg;

    logic [RANGE_W-1:0] qranges_reg [SLOT_DEPTH];
    logic [BYTE_W-1:0]  qbytes_reg  [SLOT_DEPTH];
    logic               qcancel_reg [SLOT_DEPTH];
    logic [RANGE_W-1:0] granges_reg;
    logic [BYTE_W-1:0]  gbytes_reg;

    logic               out_valid_reg;
    out_t               out_data_reg;

    logic [SLOT_W-1:0]  idx;
    logic [RANGE_W-1:0] cur_qr;
    logic [BYTE_W-1:0]  cur_qb;
    logic               cur_cf;
    logic [BYTE_W:0]    req_bytes;
    logic               qr_ok;
    logic               qb_ok;
    logic               gr_ok;
    logic               gb_ok;
    logic               qb_under;
    logic               gb_under;
    logic               qr_under;
    logic               gr_under;

    logic [RANGE_W-1:0] qranges_next;
    logic [BYTE_W-1:0]  qbytes_next;
    logic               qcancel_next;
    logic [RANGE_W-1:0] granges_next;
    logic [BYTE_W-1:0]  gbytes_next;
    out_t               result;

    assign op_pop    = op_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign idx       = op.slot[SLOT_W-1:0];
    assign cur_qr    = qranges_reg[idx];
    assign cur_qb    = qbytes_reg[idx];
    assign cur_cf    = qcancel_reg[idx];
    assign req_bytes = {{(BYTE_W + 1 - REQ_BYTE_W){1'b0}}, op.bytes};

    assign qr_ok = ({1'b0, cur_qr} + 17'd1) <= {1'b0, qmax_ranges_reg};
    assign gr_ok = ({1'b0, granges_reg} + 17'd1) <= {1'b0, gmax_ranges_reg};
    assign qb_ok = ({1'b0, cur_qb} + req_bytes) <= {1'b0, qmax_bytes_reg};
    assign gb_ok = ({1'b0, gbytes_reg} + req_bytes) <= {1'b0, gmax_bytes_reg};

    assign qb_under = op.rel_bytes && (req_bytes > {1'b0, cur_qb});
    assign gb_under = op.rel_bytes && (req_bytes > {1'b0, gbytes_reg});
    assign qr_under = op.rel_range && (cur_qr == '0);
    assign gr_under = op.rel_range && (granges_reg == '0);

    always_comb
    begin
        qranges_next   = cur_qr;
        qbytes_next    = cur_qb;
        qcancel_next   = cur_cf;
        granges_next   = granges_reg;
        gbytes_next    = gbytes_reg;
        result.status  = ST_OK;
        result.granted = 1'b0;
        case (op.kind)
            OP_OPEN:
            begin
                qcancel_next = 1'b0;
            end
            OP_CANCEL:
            begin
                qcancel_next = 1'b1;
            end
            OP_ZERO:
            begin
                result.status = ST_ZERO_BYTES;
            end
            OP_RESERVE:
            begin
                if (cur_cf)
                begin
                    result.status = ST_CANCELLED;
                end
                else if (op.take_range && !qr_ok)
                begin
                    result.status = ST_QUERY_RANGES;
                end
                else if (!qb_ok)
                begin
                    result.status = ST_QUERY_BYTES;
                end
                else if (op.take_range && !gr_ok)
                begin
                    result.status = ST_GLOBAL_RANGES;
                end
                else if (!gb_ok)
                begin
                    result.status = ST_GLOBAL_BYTES;
                end
                else
                begin
                    result.granted = 1'b1;
                    qbytes_next    = cur_qb + req_bytes[BYTE_W-1:0];
                    gbytes_next    = gbytes_reg + req_bytes[BYTE_W-1:0];
                    if (op.take_range)
                    begin
                        qranges_next = cur_qr + 1'b1;
                        granges_next = granges_reg + 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (op.rel_bytes)
                begin
                    qbytes_next = qb_under ? '0 : cur_qb - req_bytes[BYTE_W-1:0];
                    gbytes_next = gb_under ? '0 : gbytes_reg - req_bytes[BYTE_W-1:0];
                end
                if (op.rel_range)
                begin
                    qranges_next = qr_under ? '0 : cur_qr - 1'b1;
                    granges_next = gr_under ? '0 : granges_reg - 1'b1;
                end
                if (qb_under || gb_under || qr_under || gr_under)
                begin
                    result.status = ST_UNDERFLOW;
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmax_ranges_reg <= GLOBAL_MAX_RANGES_RST;
            gmax_bytes_reg  <= GLOBAL_MAX_BYTES_RST;
            qmax_ranges_reg <= QUERY_MAX_RANGES_RST;
            qmax_bytes_reg  <= QUERY_MAX_BYTES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GLOBAL_MAX_RANGES: gmax_ranges_reg <= cfg_data[RANGE_W-1:0];
                REG_GLOBAL_MAX_BYTES:  gmax_bytes_reg  <= cfg_data;
                REG_QUERY_MAX_RANGES:  qmax_ranges_reg <= cfg_data[RANGE_W-1:0];
                REG_QUERY_MAX_BYTES:   qmax_bytes_reg  <= cfg_data;
                default:               gmax_ranges_reg <= gmax_ranges_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_DEPTH; i++)
            begin
                qranges_reg[i] <= '0;
                qbytes_reg[i]  <= '0;
                qcancel_reg[i] <= 1'b0;
            end
            granges_reg <= '0;
            gbytes_reg  <= '0;
        end
        else if (op_pop)
        begin
            qranges_reg[idx] <= qranges_next;
            qbytes_reg[idx]  <= qbytes_next;
            qcancel_reg[idx] <= qcancel_next;
            granges_reg      <= granges_next;
            gbytes_reg       <= gbytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/two_level_credit_admission_unit.sv -----
`default_nettype none

// channel   direction  payload   handshake
// in        input      in_t      in_valid / in_stall
// out       output     out_t     out_valid / out_stall
// cfg       input      40 bit    cfg_write, cfg_index
//
// one request per cycle with out_stall low; out_valid is registered after the queue
// the back end reads and updates one slot and the global counters in the same cycle
// a two-entry queue sits between decode and execution; in_stall is high when it is full
// out_stall holds the output register and backs up the queue, then the input
// rst_n clears all counters and cancel flags and restores the limit registers

module two_level_credit_admission_unit #(
    parameter int unsigned QUERY_SLOTS = tlca_pkg::QUERY_SLOTS_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  tlca_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  wire                            out_stall,
    output tlca_pkg::out_t                 out_data,
    input  wire                            cfg_write,
    input  wire  [tlca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tlca_pkg::BYTE_W-1:0]    cfg_data
);
    import tlca_pkg::*;

    op_t  front_op;
    op_t  head_op;
    logic queue_full;
    logic queue_not_empty;
    logic pop;
    logic push;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    tlca_front #(
        .QUERY_SLOTS (QUERY_SLOTS)
    ) u_front (
        .req (in_data),
        .op  (front_op)
    );

    tlca_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (front_op),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_op)
    );

    tlca_back #(
        .QUERY_SLOTS (QUERY_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (queue_not_empty),
        .op        (head_op),
        .op_pop    (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- bench/two_level_credit_admission_unit_tb.sv -----
module two_level_credit_admission_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlca_pkg::*;

    localparam int unsigned SLOTS = QUERY_SLOTS_DEFAULT;
    localparam int unsigned TIMEOUT_NS = 5_000_000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [BYTE_W-1:0] BYTES_MAX = {BYTE_W{1'b1}};
    localparam logic [RANGE_W-1:0] RANGES_MAX = {RANGE_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0] cfg_data;

    logic [RANGE_W-1:0] slot_ranges [SLOTS];
    logic [BYTE_W-1:0] slot_bytes [SLOTS];
    bit slot_cancelled [SLOTS];
    logic [RANGE_W-1:0] total_ranges;
    logic [BYTE_W-1:0] total_bytes;
    logic [RANGE_W-1:0] cap_global_ranges;
    logic [BYTE_W-1:0] cap_global_bytes;
    logic [RANGE_W-1:0] cap_query_ranges;
    logic [BYTE_W-1:0] cap_query_bytes;

    out_t expected_results [$];
    int error_count = 0;
    int rx_wait = 0;
    int hold_left = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    two_level_credit_admission_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_credits();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_ranges[i] = '0;
            slot_bytes[i] = '0;
            slot_cancelled[i] = 1'b0;
        end
        total_ranges = '0;
        total_bytes = '0;
        cap_global_ranges = GLOBAL_MAX_RANGES_RST;
        cap_global_bytes = GLOBAL_MAX_BYTES_RST;
        cap_query_ranges = QUERY_MAX_RANGES_RST;
        cap_query_bytes = QUERY_MAX_BYTES_RST;
    endfunction

    function automatic bit has_room(input logic [BYTE_W-1:0] current,
                                    input logic [BYTE_W-1:0] amount,
                                    input logic [BYTE_W-1:0] cap);
        return (current <= cap) && (amount <= cap - current);
    endfunction

    // msb flags that the count would have gone below zero
    function automatic logic [BYTE_W:0] sub_floor(input logic [BYTE_W-1:0] current,
                                                  input logic [BYTE_W-1:0] amount);
        if (amount > current)
            return {1'b1, {BYTE_W{1'b0}}};
        return {1'b0, current - amount};
    endfunction

    function automatic out_t admit_request(input in_t r);
        out_t res;
        int s;
        bit takes_range;
        bit rel_range;
        bit under;
        logic [BYTE_W:0] t;
        logic [BYTE_W-1:0] amt;
        res.status = ST_OK;
        res.granted = 1'b0;
        s = int'(r.query_slot);
        amt = BYTE_W'(r.bytes);
        under = 1'b0;
        case (r.action)
            ACT_OPEN: slot_cancelled[s] = 1'b0;
            ACT_CANCEL: slot_cancelled[s] = 1'b1;
            ACT_RESERVE_RANGE, ACT_RESERVE_WB:
            begin
                takes_range = (r.action == ACT_RESERVE_RANGE);
                if (r.bytes == '0)
                    res.status = ST_ZERO_BYTES;
                else if (slot_cancelled[s])
                    res.status = ST_CANCELLED;
                else if (takes_range && !has_room(BYTE_W'(slot_ranges[s]), BYTE_W'(1),
                                                  BYTE_W'(cap_query_ranges)))
                    res.status = ST_QUERY_RANGES;
                else if (!has_room(slot_bytes[s], amt, cap_query_bytes))
                    res.status = ST_QUERY_BYTES;
                else if (takes_range && !has_room(BYTE_W'(total_ranges), BYTE_W'(1),
                                                  BYTE_W'(cap_global_ranges)))
                    res.status = ST_GLOBAL_RANGES;
                else if (!has_room(total_bytes, amt, cap_global_bytes))
                    res.status = ST_GLOBAL_BYTES;
                else
                begin
                    if (takes_range)
                    begin
                        slot_ranges[s] = slot_ranges[s] + 1'b1;
                        total_ranges = total_ranges + 1'b1;
                    end
                    slot_bytes[s] = slot_bytes[s] + amt;
                    total_bytes = total_bytes + amt;
                    res.granted = 1'b1;
                end
            end
            ACT_RELEASE_RANGE, ACT_RELEASE_RESV:
            begin
                rel_range = (r.action == ACT_RELEASE_RANGE) || r.range_held;
                if (r.action == ACT_RELEASE_RESV && r.bytes != '0)
                begin
                    t = sub_floor(slot_bytes[s], amt);
                    under |= t[BYTE_W];
                    slot_bytes[s] = t[BYTE_W-1:0];
                    t = sub_floor(total_bytes, amt);
                    under |= t[BYTE_W];
                    total_bytes = t[BYTE_W-1:0];
                end
                if (rel_range)
                begin
                    t = sub_floor(BYTE_W'(slot_ranges[s]), BYTE_W'(1));
                    under |= t[BYTE_W];
                    slot_ranges[s] = t[RANGE_W-1:0];
                    t = sub_floor(BYTE_W'(total_ranges), BYTE_W'(1));
                    under |= t[BYTE_W];
                    total_ranges = t[RANGE_W-1:0];
                end
                if (under)
                    res.status = ST_UNDERFLOW;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic in_t make_request(input logic [2:0] action,
                                         input logic [SLOT_FIELD_W-1:0] slot,
                                         input logic [REQ_BYTE_W-1:0] bytes,
                                         input logic held);
        in_t r;
        r.action = action;
        r.query_slot = slot;
        r.bytes = bytes;
        r.range_held = held;
        return r;
    endfunction

    function automatic logic [REQ_BYTE_W-1:0] rand_bytes(input logic [REQ_BYTE_W-1:0] scale);
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return REQ_BYTE_W'(1);
            default: return $urandom_range(1, scale);
        endcase
    endfunction

    // reserves dominate, releases keep the counters moving, a few slot and spare ops
    function automatic in_t random_request(input logic [REQ_BYTE_W-1:0] scale);
        in_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.action = ACT_OPEN;
        else if (pick < 9)
            r.action = ACT_CANCEL;
        else if (pick < 40)
            r.action = ACT_RESERVE_RANGE;
        else if (pick < 55)
            r.action = ACT_RESERVE_WB;
        else if (pick < 72)
            r.action = ACT_RELEASE_RANGE;
        else if (pick < 95)
            r.action = ACT_RELEASE_RESV;
        else
            r.action = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        if ($urandom_range(0, 1) != 0)
            r.query_slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
        else
            r.query_slot = SLOT_FIELD_W'($urandom_range(0, 3));
        r.bytes = rand_bytes(scale);
        r.range_held = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(input in_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_data = r;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(admit_request(r));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_GLOBAL_MAX_RANGES: cap_global_ranges = value[RANGE_W-1:0];
            REG_GLOBAL_MAX_BYTES: cap_global_bytes = value;
            REG_QUERY_MAX_RANGES: cap_query_ranges = value[RANGE_W-1:0];
            REG_QUERY_MAX_BYTES: cap_query_bytes = value;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input logic [RANGE_W-1:0] global_ranges,
                                input logic [BYTE_W-1:0] global_bytes,
                                input logic [RANGE_W-1:0] query_ranges,
                                input logic [BYTE_W-1:0] query_bytes);
        set_limit(REG_GLOBAL_MAX_RANGES, BYTE_W'(global_ranges));
        set_limit(REG_GLOBAL_MAX_BYTES, global_bytes);
        set_limit(REG_QUERY_MAX_RANGES, BYTE_W'(query_ranges));
        set_limit(REG_QUERY_MAX_BYTES, query_bytes);
    endtask

    task automatic test_zero_and_cancel();
        send_request(make_request(ACT_RESERVE_RANGE, 4'd0, 32'd0, 1'b0));
        send_request(make_request(ACT_CANCEL, 4'd15, 32'd0, 1'b0));
        // zero bytes wins over a cancelled slot
        send_request(make_request(ACT_RESERVE_WB, 4'd15, 32'd0, 1'b1));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd15, 32'd100, 1'b0));
        send_request(make_request(ACT_OPEN, 4'd15, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd15, 32'hFFFF_FFFF, 1'b0));
        send_request(make_request(ACT_SPARE_LO, 4'd15, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(ACT_SPARE_HI, 4'd0, 32'd7, 1'b0));
        drain_results();
    endtask

    task automatic test_release_underflow();
        send_request(make_request(ACT_RELEASE_RANGE, 4'd1, 32'd0, 1'b0));
        send_request(make_request(ACT_RELEASE_RESV, 4'd1, 32'd0, 1'b0));
        send_request(make_request(ACT_RELEASE_RESV, 4'd1, 32'd5, 1'b1));
        drain_results();
    endtask

    task automatic test_limit_checks();
        apply_limits(16'd2, 40'd1000, 16'd1, 40'd600);
        send_request(make_request(ACT_RESERVE_RANGE, 4'd2, 32'd500, 1'b0));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd2, 32'd1, 1'b0));
        send_request(make_request(ACT_RESERVE_WB, 4'd2, 32'd101, 1'b0));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd3, 32'd500, 1'b0));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd4, 32'd1, 1'b0));
        send_request(make_request(ACT_RESERVE_WB, 4'd4, 32'd1, 1'b0));
        send_request(make_request(ACT_RELEASE_RESV, 4'd2, 32'd500, 1'b1));
        drain_results();
    endtask

    // limits lowered under counts already held
    task automatic test_limit_below_count();
        apply_limits(16'd1, 40'd100, 16'd1, 40'd100);
        send_request(make_request(ACT_RESERVE_WB, 4'd3, 32'd1, 1'b0));
        send_request(make_request(ACT_RESERVE_RANGE, 4'd5, 32'd1, 1'b0));
        send_request(make_request(ACT_RESERVE_WB, 4'd5, 32'd1, 1'b0));
        send_request(make_request(ACT_RELEASE_RANGE, 4'd3, 32'd0, 1'b0));
        send_request(make_request(ACT_RELEASE_RESV, 4'd3, 32'd600, 1'b0));
        drain_results();
    endtask

    task automatic run_random(input int count, input logic [REQ_BYTE_W-1:0] scale);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            send_request(random_request(scale));
        end
        drain_results();
    endtask

    task automatic test_random_limits();
        apply_limits(16'd8, 40'd20000, 16'd3, 40'd6000);
        run_random(300, 32'd3000);
        apply_limits(RANGES_MAX, BYTES_MAX, RANGES_MAX, BYTES_MAX);
        run_random(300, 32'hFFFF_FFFF);
        apply_limits(16'd1, 40'd1, 16'd1, 40'd1);
        run_random(300, 32'd2);
        apply_limits(16'd4, 40'd3000, RANGES_MAX, BYTES_MAX);
        run_random(300, 32'd1000);
        apply_limits(GLOBAL_MAX_RANGES_RST, GLOBAL_MAX_BYTES_RST,
                     QUERY_MAX_RANGES_RST, QUERY_MAX_BYTES_RST);
        run_random(300, 32'h00FF_FFFF);
    endtask

    // receiver holds off while requests keep coming back to back
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        @(negedge clk);
        hold_left = HOLD_CYCLES;
        repeat (40)
            send_request(random_request(32'h00FF_FFFF));
        drain_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (expected_results.size() == 0)
            report_mismatch($sformatf("unexpected result status %0d granted %0d",
                                      got.status, got.granted));
        else
        begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.granted !== want.granted)
                report_mismatch($sformatf("granted %0d, expected %0d",
                                          got.granted, want.granted));
        end
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
                check_result(out_data);
            @(negedge clk);
            if (hold_left > 0)
                out_stall = 1'b1;
            else if (rx_wait > 0)
            begin
                out_stall = 1'b1;
                rx_wait--;
            end
            else
                out_stall = 1'b0;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("** two_level_credit_admission_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        reset_credits();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_zero_and_cancel();
        test_release_underflow();
        test_limit_checks();
        test_limit_below_count();
        test_random_limits();
        test_backpressure();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("** two_level_credit_admission_unit: PASSED **");
        else
            $display("** two_level_credit_admission_unit: FAILED **");
        $finish;
    end

endmodule
